FILE: rtl/core/cms_pkg.sv
// Shared types and constants for the count-min sketch with decay.
package cms_pkg;

  localparam int unsigned CntW   = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned WgtW   = 16;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned BcW    = 11;
  localparam int unsigned FacW   = 17;
  localparam int unsigned CoefW  = 16;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_DECAY  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BUCKETS = 2'd0,
    REG_MULT    = 2'd1,
    REG_OFFS    = 2'd2,
    REG_FACTOR  = 2'd3
  } reg_e;

  typedef struct packed {
    op_e              op;
    logic [KeyW-1:0]  node_id;
    logic [WgtW-1:0]  weight;
  } cmd_t;

endpackage

FILE: rtl/core/count_min_sketch_with_decay_top.sv
// Top level of the count-min sketch with decay.
// Insert and query run, per row, a bit-serial modulo of the 49-bit hash and then
// a counter read; an insert also writes the updated counter back. Clear and decay
// sweep all Rows*MaxBuckets counters through one RAM: clear writes each counter,
// decay reads, scales and writes back each counter in turn. After reset a clearing
// pass over all counters runs before the first word is carried out; up to two words
// are taken into the queue meanwhile. A two-word queue decouples input.
module count_min_sketch_with_decay_top
  import cms_pkg::*;
#(
  parameter int unsigned Rows       = 2,
  parameter int unsigned MaxBuckets = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [KeyW-1:0]    node_id_i,
  input  logic [WgtW-1:0]    weight_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [CntW-1:0]    estimate_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;
  logic [BcW-1:0]  bc;
  logic [CfgW-1:0] mult, offs;
  logic [FacW-1:0] fac;

  cms_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .op_i, .node_id_i, .weight_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd),
    .bucket_count_o(bc), .mult_o(mult), .offs_o(offs), .factor_o(fac)
  );

  cms_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_ready_o(f_ready), .in_cmd_i(f_cmd),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_cmd_o(b_cmd)
  );

  cms_back #(.Rows(Rows), .MaxBuckets(MaxBuckets)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .bucket_count_i(bc), .mult_i(mult), .offs_i(offs), .factor_i(fac),
    .res_valid_o(valid_o), .res_ready_i(ready_i), .estimate_o
  );

endmodule

FILE: rtl/core/cms_ram.sv
// Generic RAM with one write port and one registered read port.
module cms_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/cms_queue.sv
// Two-entry command queue between front and back.
module cms_queue
  import cms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);

  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_cmd_o   = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      buf_q[wp_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wp_q <= ~wp_q;
      if (out_valid_o && out_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_o) - 2'(out_valid_o && out_ready_i);
    end
  end

endmodule

FILE: rtl/core/cms_back.sv
// Back end: hashing, counter updates, sweeps and result register.
module cms_back
  import cms_pkg::*;
#(
  parameter int unsigned Rows       = 2,
  parameter int unsigned MaxBuckets = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_t                cmd_i,
  input  logic [BcW-1:0]      bucket_count_i,
  input  logic [CfgW-1:0]     mult_i,
  input  logic [CfgW-1:0]     offs_i,
  input  logic [FacW-1:0]     factor_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [CntW-1:0]     estimate_o
);

  localparam int unsigned RowW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned BktW   = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned Depth  = Rows * MaxBuckets;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned HashW  = KeyW + CoefW + 1;
  localparam int unsigned BIdxW  = $clog2(MaxBuckets + 1);
  localparam logic [AddrW:0] LastAddr = (AddrW+1)'(Depth - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MUL, S_MOD, S_RD, S_WAIT, S_UPD, S_NEXT,
    S_DRD, S_DWAIT, S_DMUL, S_DWR, S_OUT
  } state_e;

  state_e              state_q;
  cmd_t                cmd_q;
  logic [RowW-1:0]     row_q;
  logic [HashW-1:0]    rem_q;
  logic [HashW-1:0]    div_q;
  logic [$clog2(HashW+1)-1:0] bit_q;
  logic [AddrW:0]      sweep_q;
  logic [CntW-1:0]     min_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW+FacW-1:0] prod_q;
  logic                res_valid_q;
  logic [CntW-1:0]     est_q;

  logic                we;
  logic [AddrW-1:0]    waddr, raddr;
  logic [CntW-1:0]     wdata, rdata;
  logic [BIdxW-1:0]    beff;
  logic [CoefW-1:0]    m_r, o_r;
  logic [HashW-1:0]    rem_sh;
  logic [CntW:0]       sum;
  logic [CntW+FacW-16-1:0] scaled;
  logic [AddrW-1:0]    slot;

  cms_ram #(.Width(CntW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    if (bucket_count_i < BcW'(2)) beff = BIdxW'(2);
    else if (32'(bucket_count_i) > MaxBuckets) beff = BIdxW'(MaxBuckets);
    else beff = BIdxW'(bucket_count_i);
    m_r = mult_i[CoefW*row_q +: CoefW];
    o_r = offs_i[CoefW*row_q +: CoefW];
    rem_sh = {rem_q[HashW-2:0], div_q[HashW-1]};
    sum = {1'b0, cnt_q} + (CntW+1)'(cmd_q.weight);
    scaled = prod_q[CntW+FacW-1:16];
    slot = AddrW'(row_q) * AddrW'(MaxBuckets) + AddrW'(rem_q[BktW-1:0]);
    if (Rows == 1) slot = AddrW'(rem_q[BktW-1:0]);
  end

  always_comb begin
    we = 1'b0;
    waddr = slot;
    wdata = '0;
    raddr = slot;
    unique case (state_q)
      S_CLR: begin
        we = 1'b1; waddr = sweep_q[AddrW-1:0];
      end
      S_UPD: begin
        we = (cmd_q.op == OP_INSERT);
        wdata = sum[CntW] ? '1 : sum[CntW-1:0];
      end
      S_DRD: raddr = sweep_q[AddrW-1:0];
      S_DWR: begin
        we = 1'b1; waddr = sweep_q[AddrW-1:0];
        wdata = (|scaled[CntW+FacW-16-1:CntW]) ? '1 : scaled[CntW-1:0];
      end
      default: ;
    endcase
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign estimate_o  = est_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      sweep_q     <= '0;
      res_valid_q <= 1'b0;
      est_q       <= '0;
      row_q       <= '0;
      cmd_q       <= '{op: OP_INSERT, node_id: '0, weight: '0};
      rem_q <= '0; div_q <= '0; bit_q <= '0; min_q <= '0; cnt_q <= '0; prod_q <= '0;
    end else begin
      if (res_valid_q && res_ready_i && (state_q != S_OUT)) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_valid_i) begin
          cmd_q   <= cmd_i;
          row_q   <= '0;
          min_q   <= '1;
          sweep_q <= '0;
          unique case (cmd_i.op)
            OP_CLEAR: state_q <= S_CLR;
            OP_DECAY: state_q <= S_DRD;
            default:  state_q <= S_MUL;
          endcase
        end
        S_CLR: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == LastAddr) state_q <= (cmd_q.op == OP_CLEAR) ? S_OUT : S_IDLE;
        end
        S_MUL: begin
          div_q   <= HashW'(cmd_q.node_id) * HashW'(m_r) + HashW'(o_r);
          rem_q   <= '0;
          bit_q   <= '0;
          state_q <= S_MOD;
        end
        S_MOD: begin
          div_q <= div_q << 1;
          rem_q <= (rem_sh >= HashW'(beff)) ? rem_sh - HashW'(beff) : rem_sh;
          bit_q <= bit_q + 1'b1;
          if (32'(bit_q) == HashW - 1) state_q <= S_RD;
        end
        S_RD:   state_q <= S_WAIT;
        S_WAIT: begin
          cnt_q   <= rdata;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (cnt_q < min_q) min_q <= cnt_q;
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          if (32'(row_q) == Rows - 1) begin
            state_q <= S_OUT;
          end else begin
            row_q   <= row_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_DRD:   state_q <= S_DWAIT;
        S_DWAIT: begin
          cnt_q   <= rdata;
          state_q <= S_DMUL;
        end
        S_DMUL: begin
          prod_q  <= cnt_q * factor_i;
          state_q <= S_DWR;
        end
        S_DWR: begin
          sweep_q <= sweep_q + 1'b1;
          state_q <= (sweep_q == LastAddr) ? S_OUT : S_DRD;
        end
        S_OUT: if (!res_valid_q || res_ready_i) begin
          res_valid_q <= 1'b1;
          est_q       <= (cmd_q.op == OP_QUERY) ? min_q : '0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/cms_front.sv
// Front end: input acceptance, classification and configuration registers.
module cms_front
  import cms_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [KeyW-1:0]  node_id_i,
  input  logic [WgtW-1:0]  weight_i,
  input  logic             cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cmd_t             cmd_o,
  output logic [BcW-1:0]   bucket_count_o,
  output logic [CfgW-1:0]  mult_o,
  output logic [CfgW-1:0]  offs_o,
  output logic [FacW-1:0]  factor_o
);

  logic [BcW-1:0]  bc_q;
  logic [CfgW-1:0] mult_q, offs_q;
  logic [FacW-1:0] fac_q;

  assign cmd_valid_o = valid_i;
  assign ready_o     = cmd_ready_i;
  assign cmd_o       = '{op: op_e'(op_i), node_id: node_id_i,
                         weight: (op_e'(op_i) == OP_INSERT) ? weight_i : '0};
  assign bucket_count_o = bc_q;
  assign mult_o   = mult_q;
  assign offs_o   = offs_q;
  assign factor_o = fac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q   <= BcW'(769);
      mult_q <= 64'h0001_0001_0001_0001;
      offs_q <= '0;
      fac_q  <= FacW'(32768);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_BUCKETS: bc_q   <= cfg_data_i[BcW-1:0];
        REG_MULT:    mult_q <= cfg_data_i;
        REG_OFFS:    offs_q <= cfg_data_i;
        REG_FACTOR:  fac_q  <= cfg_data_i[FacW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/cms_checker.sv
// Port-level checker for the count-min sketch top level.
module cms_checker
  import cms_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            valid_i,
  input logic            ready_o,
  input logic            valid_o,
  input logic            ready_i,
  input logic [CntW-1:0] estimate_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(estimate_o))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_o |=> valid_i)
    else $error("input word withdrawn before acceptance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !$isunknown(estimate_o))
    else $error("estimate unknown while valid");

  assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o)
    else $error("result valid during reset");

endmodule

bind count_min_sketch_with_decay_top cms_checker u_cms_checker (
  .clk_i, .rst_ni, .valid_i, .ready_o, .valid_o, .ready_i, .estimate_o
);
